### hdl/pirl_pkg.sv
package pirl_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int DATA_W   = 32;

	localparam logic [1:0] MODE_APPEND = 2'd0;
	localparam logic [1:0] MODE_INSERT = 2'd1;
	localparam logic [1:0] MODE_REMOVE = 2'd2;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_NO_ELEMENT = 2'd1;
	localparam logic [1:0] ST_FULL       = 2'd2;

	// broadcast to every cell of the row
	typedef struct packed {
		logic              en;
		logic [1:0]        op;
		logic [CNT_W-1:0]  pos;
		logic [CNT_W-1:0]  cnt;
		logic [DATA_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic [DATA_W-1:0] removed_value;
		logic [1:0]        status;
		logic [4:0]        count;
	} res_t;

endpackage

### hdl/pirl_cell.sv
module pirl_cell import pirl_pkg::*; (
	input  logic              clk,
	input  cmd_t              cmd,
	input  logic [IDX_W-1:0]  idx,
	input  logic [DATA_W-1:0] left_data,
	input  logic [DATA_W-1:0] right_data,
	output logic [DATA_W-1:0] data,
	output logic [DATA_W-1:0] tap
);

	logic [DATA_W-1:0] data_q;
	logic [DATA_W-1:0] data_nxt;
	logic [CNT_W-1:0]  me;

	assign me   = CNT_W'(idx);
	assign data = data_q;
	assign tap  = (me == cmd.pos) ? data_q : '0;

	always_comb begin
		data_nxt = data_q;
		if (cmd.en) begin
			unique case (cmd.op)
				MODE_APPEND: begin
					if (me == cmd.cnt) data_nxt = cmd.value;
				end
				MODE_INSERT: begin
					if (me == cmd.pos) data_nxt = cmd.value;
					else if (me > cmd.pos && me <= cmd.cnt) data_nxt = left_data;
				end
				MODE_REMOVE: begin
					// cnt is at least one whenever a remove is enabled
					if (me >= cmd.pos && me < cmd.cnt - CNT_W'(1)) data_nxt = right_data;
				end
				default: data_nxt = data_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_nxt;
	end

endmodule

### hdl/pirl_outbuf.sv
module pirl_outbuf import pirl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t push_data,
	output logic full,
	output logic out_valid,
	input  logic out_stall,
	output res_t out_data
);

	logic out_valid_q;
	logic skid_valid_q;
	res_t out_data_q;
	res_t skid_data_q;
	logic take;
	logic load_out;

	assign take      = out_valid_q & ~out_stall;
	assign load_out  = ~out_valid_q | take;
	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q  <= skid_valid_q | push;
			skid_valid_q <= skid_valid_q & push;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q <= skid_valid_q ? skid_data_q : push_data;
			if (skid_valid_q) skid_data_q <= push_data;
		end else if (push) begin
			skid_data_q <= push_data;
		end
	end

endmodule

### hdl/positional_insert_remove_list.sv
// Bounded ordered list of signed 32-bit values, entry 0 at the front.
// Input channel (in_valid / in_stall): mode, value, position. Mode 0 appends,
// mode 1 inserts before position, mode 2 removes the entry at position.
// Output channel (out_valid / out_stall): removed_value, status, count, one
// result per request, in request order.
// The list sits in a row of CAPACITY cells; the affected cells update in the
// cycle a request is taken, shifting later entries up or down one place, so
// one request can be taken every cycle while in_stall is low.
// Each result is registered in the output buffer before it shows on out_valid.
// A two-entry output buffer decouples the sides; in_stall rises only when both
// entries hold results that the receiver has not taken, and a stalled result
// holds steady until taken.
// Reset empties the list and the output buffer; no clearing pass is needed,
// cells at or past the count are never read.
module positional_insert_remove_list import pirl_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               mode,
	input  logic signed [DATA_W-1:0] value,
	input  logic [7:0]               position,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] removed_value,
	output logic [1:0]               status,
	output logic [4:0]               count
);

	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_nxt;
	logic              accept;
	logic              pos_ok;
	logic              is_full;
	logic              do_op;
	logic [1:0]        st;
	logic [DATA_W-1:0] taken;
	cmd_t              cmd;
	res_t              res;
	res_t              out_res;
	logic              buf_full;

	logic [DATA_W-1:0] cell_data [CAPACITY];
	logic [DATA_W-1:0] cell_tap  [CAPACITY];

	assign in_stall = buf_full;
	assign accept   = in_valid & ~in_stall;
	assign pos_ok   = 9'(position) < 9'(count_q);
	assign is_full  = count_q == CNT_W'(CAPACITY);

	always_comb begin
		taken = '0;
		for (int i = 0; i < CAPACITY; i++) taken = taken | cell_tap[i];
	end

	always_comb begin
		do_op     = 1'b0;
		st        = ST_OK;
		count_nxt = count_q;
		unique case (mode)
			MODE_APPEND: begin
				if (is_full) st = ST_FULL;
				else begin
					do_op     = 1'b1;
					count_nxt = count_q + CNT_W'(1);
				end
			end
			MODE_INSERT: begin
				if (!pos_ok) st = ST_NO_ELEMENT;
				else if (is_full) st = ST_FULL;
				else begin
					do_op     = 1'b1;
					count_nxt = count_q + CNT_W'(1);
				end
			end
			MODE_REMOVE: begin
				if (!pos_ok) st = ST_NO_ELEMENT;
				else begin
					do_op     = 1'b1;
					count_nxt = count_q - CNT_W'(1);
				end
			end
			default: st = ST_OK;
		endcase
	end

	assign cmd.en    = accept & do_op;
	assign cmd.op    = mode;
	assign cmd.pos   = CNT_W'(position);
	assign cmd.cnt   = count_q;
	assign cmd.value = value;

	assign res.removed_value = (mode == MODE_REMOVE && do_op) ? taken : '0;
	assign res.status        = st;
	assign res.count         = 5'(count_nxt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) count_q <= '0;
		else if (accept) count_q <= count_nxt;
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [DATA_W-1:0] left_in;
		logic [DATA_W-1:0] right_in;
		if (g == 0) begin : g_first
			assign left_in = '0;
		end else begin : g_mid_l
			assign left_in = cell_data[g-1];
		end
		if (g == CAPACITY - 1) begin : g_last
			assign right_in = '0;
		end else begin : g_mid_r
			assign right_in = cell_data[g+1];
		end
		pirl_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.idx        (IDX_W'(g)),
			.left_data  (left_in),
			.right_data (right_in),
			.data       (cell_data[g]),
			.tap        (cell_tap[g])
		);
	end

	pirl_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (res),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_res)
	);

	assign removed_value = out_res.removed_value;
	assign status        = out_res.status;
	assign count         = out_res.count;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count beyond capacity");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> count == 5'(CAPACITY))
		else $error("full status while list not full");

	a_removed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> removed_value == '0)
		else $error("removed value on failed request");

	a_append_count: assert property (@(posedge clk) disable iff (!arst_n)
		accept && mode == MODE_APPEND && !is_full |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("append did not grow the list");

endmodule

### bench/tb_positional_insert_remove_list.sv
`timescale 1ns / 1ps
module tb_positional_insert_remove_list;
	import pirl_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_ITEMS = 850;
	localparam int CALM_TAIL = 110;

	// Tracks the list contents as transfers go in and checks results coming out.
	class list_tracker;
		logic [DATA_W-1:0] cells [CAPACITY];
		int fill;
		res_t owed_results [$];
		int errors;

		function new();
			fill = 0;
			errors = 0;
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= 10)
				$display("mismatch at %0t: %s", $realtime, msg);
		endfunction

		function void note_request(logic [1:0] md, logic [DATA_W-1:0] v, logic [7:0] p);
			res_t r;
			int i;
			r.removed_value = '0;
			r.status = ST_OK;
			case (md)
				MODE_APPEND: begin
					if (fill >= CAPACITY)
						r.status = ST_FULL;
					else begin
						cells[fill] = v;
						fill++;
					end
				end
				MODE_INSERT: begin
					// bad position wins over a full list
					if (int'(p) >= fill)
						r.status = ST_NO_ELEMENT;
					else if (fill >= CAPACITY)
						r.status = ST_FULL;
					else begin
						for (i = fill; i > int'(p); i--)
							cells[i] = cells[i - 1];
						cells[p] = v;
						fill++;
					end
				end
				MODE_REMOVE: begin
					if (int'(p) >= fill)
						r.status = ST_NO_ELEMENT;
					else begin
						r.removed_value = cells[p];
						for (i = int'(p); i < fill - 1; i++)
							cells[i] = cells[i + 1];
						fill--;
					end
				end
				default: begin
				end
			endcase
			r.count = fill[4:0];
			owed_results.push_back(r);
		endfunction

		function void check_result(logic [DATA_W-1:0] rv, logic [1:0] st, logic [4:0] cn);
			res_t want;
			if (owed_results.size() == 0) begin
				flag($sformatf("result with nothing owed: removed=%0d status=%0d count=%0d",
					$signed(rv), st, cn));
				return;
			end
			want = owed_results.pop_front();
			if (rv !== want.removed_value || st !== want.status || cn !== want.count)
				flag($sformatf("expected removed=%0d status=%0d count=%0d, got removed=%0d status=%0d count=%0d",
					$signed(want.removed_value), want.status, want.count,
					$signed(rv), st, cn));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] mode = MODE_APPEND;
	logic signed [DATA_W-1:0] value = '0;
	logic [7:0] position = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [DATA_W-1:0] removed_value;
	logic [1:0] status;
	logic [4:0] count;

	list_tracker list_model = new();
	logic gaps_on = 1'b1;
	logic hold_off = 1'b0;
	int stall_left = 0;
	int n_sent = 0;
	int cycles = 0;

	positional_insert_remove_list dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.value(value),
		.position(position),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.removed_value(removed_value),
		.status(status),
		.count(count)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_positional_insert_remove_list: FAIL");
			$finish;
		end
	end

	// receiver: check every output transfer, stall in bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && !out_stall)
				list_model.check_result(removed_value, status, count);
			if (hold_off)
				out_stall <= 1'b1;
			else if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left <= stall_left - 1;
			end else if (gaps_on && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				stall_left <= $urandom_range(0, 3);
			end else
				out_stall <= 1'b0;
		end
	end

	// long receiver hold-off so the output buffer fills and in_stall rises
	initial begin
		wait (n_sent >= 300);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (48) @(posedge clk);
		hold_off <= 1'b0;
	end

	task automatic send_request(input logic [1:0] md, input logic [DATA_W-1:0] v,
		input logic [7:0] p);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= md;
		value <= v;
		position <= p;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		list_model.note_request(md, v, p);
		n_sent++;
	endtask

	initial begin
		int k;
		int tilt;
		int roll;
		int fill_now;
		logic [1:0] md;
		logic [DATA_W-1:0] v;
		logic [7:0] p;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty-list misses, unused mode, extremes, edges of the list
		send_request(MODE_INSERT, 32'h1234_5678, 8'd0);
		send_request(MODE_REMOVE, 32'hFFFF_FFFF, 8'd0);
		send_request(MODE_UNUSED, 32'hDEAD_BEEF, 8'hFF);
		send_request(MODE_APPEND, 32'h7FFF_FFFF, 8'hFF);
		send_request(MODE_APPEND, 32'h8000_0000, 8'h00);
		send_request(MODE_INSERT, 32'h0000_0000, 8'd0);
		send_request(MODE_INSERT, 32'hFFFF_FFFF, 8'd2);
		send_request(MODE_REMOVE, 32'h0, 8'hFF);
		send_request(MODE_INSERT, 32'h5555_AAAA, 8'd4);
		send_request(MODE_REMOVE, 32'h0, 8'd0);
		send_request(MODE_REMOVE, 32'h0, 8'd2);
		while (list_model.fill < CAPACITY)
			send_request(MODE_APPEND, $urandom, 8'($urandom));
		send_request(MODE_APPEND, 32'h0BAD_F00D, 8'd0);
		send_request(MODE_INSERT, 32'h0BAD_F00D, 8'd5);
		send_request(MODE_INSERT, 32'h0BAD_F00D, 8'd16);
		send_request(MODE_REMOVE, 32'h0, 8'd15);

		// random: segments lean toward growing, shrinking or a milder growth
		tilt = 0;
		for (k = 0; k < RANDOM_ITEMS; k++) begin
			if (k % 40 == 0) begin
				tilt = $urandom_range(0, 2);
				gaps_on <= (k < RANDOM_ITEMS - CALM_TAIL) && ($urandom_range(0, 3) != 0);
			end
			fill_now = list_model.fill;
			roll = $urandom_range(0, 99);
			if (roll < 2)
				md = MODE_UNUSED;
			else if (tilt == 0)
				md = roll < 50 ? MODE_APPEND : (roll < 80 ? MODE_INSERT : MODE_REMOVE);
			else if (tilt == 1)
				md = roll < 15 ? MODE_APPEND : (roll < 35 ? MODE_INSERT : MODE_REMOVE);
			else
				md = roll < 30 ? MODE_APPEND : (roll < 60 ? MODE_INSERT : MODE_REMOVE);
			roll = $urandom_range(0, 99);
			if (roll < 8 || fill_now == 0)
				p = 8'($urandom_range(0, 255));
			else if (roll < 14)
				p = 8'(fill_now);
			else
				p = 8'($urandom_range(0, fill_now - 1));
			roll = $urandom_range(0, 19);
			case (roll)
				0: v = 32'h8000_0000;
				1: v = 32'h7FFF_FFFF;
				default: v = $urandom;
			endcase
			send_request(md, v, p);
		end
		in_valid <= 1'b0;

		while (list_model.owed_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (list_model.errors == 0 && list_model.owed_results.size() == 0)
			$display("tb_positional_insert_remove_list: PASS");
		else
			$display("tb_positional_insert_remove_list: FAIL");
		$finish;
	end

endmodule

### sim.f
hdl/pirl_pkg.sv
hdl/pirl_cell.sv
hdl/pirl_outbuf.sv
hdl/positional_insert_remove_list.sv
bench/tb_positional_insert_remove_list.sv
